/* src/q2e_pkg.sv */
// ----------------------------------------------------------------------------
// q2e_pkg: shared types, constants and functions
// Fixed-point formats, request/result structs and CORDIC constants for the
// quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

    // Input component width and number of CORDIC micro-rotations
    localparam int CW    = 32;
    localparam int STEPS = 28;

    // Internal formats
    localparam int OPW   = 56;              // atan2 operand, Q.50
    localparam int XW    = 60;              // CORDIC x/y datapath
    localparam int ZW    = 64;              // CORDIC angle, Q.60
    localparam int SHW   = $clog2(STEPS);   // shift index
    localparam int SQD   = 31;              // root digits of a 61-bit radicand
    localparam int RADW  = 2 * SQD;         // radicand bits
    localparam int REMW  = SQD + 3;         // partial remainder

    localparam logic signed [ZW-1:0] PI_Q60  = 64'sh3243F6A8885A308D;
    localparam logic signed [63:0]   ONE_Q58 = 64'sd1 <<< 58;

    typedef struct packed {
        logic signed [CW-1:0] quat_w;
        logic signed [CW-1:0] quat_x;
        logic signed [CW-1:0] quat_y;
        logic signed [CW-1:0] quat_z;
    } t_quat_req;

    typedef struct packed {
        logic signed [31:0] roll_angle;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] yaw_angle;
        logic               pitch_clamped;
    } t_euler_res;

    // One CORDIC lane in flight
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } t_cordic_lane;

    // One square-root lane in flight
    typedef struct packed {
        logic [REMW-1:0] rem;
        logic [SQD-1:0]  root;
        logic [RADW-1:0] rad;
    } t_sqrt_lane;

    // Operands waiting beside the square root
    typedef struct packed {
        logic signed [OPW-1:0] roll_y;
        logic signed [OPW-1:0] roll_x;
        logic signed [OPW-1:0] yaw_y;
        logic signed [OPW-1:0] yaw_x;
        logic signed [OPW-1:0] sin_y;
        logic                  clamp;
    } t_side;

    // Component to Q2.30
    function automatic logic signed [31:0] to_q30(input logic signed [CW-1:0] v);
        logic signed [CW+31:0] ext;
        ext = {{32{v[CW-1]}}, v};
        if (CW >= 32) begin
            ext = ext >>> (CW - 32);
        end else begin
            ext = ext <<< (32 - CW);
        end
        return ext[31:0];
    endfunction

    // Long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q.60 from the series, terms truncated in Q.62
    function automatic logic signed [ZW-1:0] atan_q60(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        logic        add;
        sum = '0;
        add = 1'b1;
        if (i == 0) begin
            return PI_Q60 >>> 2;
        end
        for (int n = 1; n < 64; n += 2) begin
            if (i * n <= 62) begin
                term = udiv64(64'd1 << (62 - i * n), 64'(n));
                sum  = add ? sum + term : sum - term;
                add  = ~add;
            end
        end
        return ZW'(sum >> 2);
    endfunction

    // Quadrant fold before the rotations
    function automatic t_cordic_lane prerot(input logic signed [OPW-1:0] y,
                                            input logic signed [XW-1:0]  x);
        t_cordic_lane l;
        l.x    = x;
        l.y    = XW'(y);
        l.z    = '0;
        l.zero = (x == '0) && (y == '0);
        if (x[XW-1]) begin
            l.z = y[OPW-1] ? -PI_Q60 : PI_Q60;
            l.x = -l.x;
            l.y = -l.y;
        end
        return l;
    endfunction

    // Round Q.60 half up to Q3.29
    function automatic logic signed [31:0] round_q29(input t_cordic_lane l);
        logic signed [ZW-1:0] rz;
        rz = l.z + (ZW'(1) <<< 30);
        return l.zero ? 32'sd0 : rz[62:31];
    endfunction

endpackage

/* src/q2e_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// q2e_sqrt_cell: one digit of the integer square root
// Restoring digit step; takes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell (
    input  logic                  i_clk,
    input  q2e_pkg::t_sqrt_lane   i_lane,
    output q2e_pkg::t_sqrt_lane   o_lane
);
    import q2e_pkg::*;

    t_sqrt_lane      r_lane;
    t_sqrt_lane      n_lane;
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;

    always_comb begin
        rem_sh     = {i_lane.rem[REMW-3:0], i_lane.rad[RADW-1 -: 2]};
        trial      = REMW'({i_lane.root, 2'b01});
        n_lane.rad = {i_lane.rad[RADW-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_lane.rem  = rem_sh - trial;
            n_lane.root = {i_lane.root[SQD-2:0], 1'b1};
        end else begin
            n_lane.rem  = rem_sh;
            n_lane.root = {i_lane.root[SQD-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

/* src/q2e_cordic_cell.sv */
// ----------------------------------------------------------------------------
// q2e_cordic_cell: one vectoring micro-rotation
// Drives y toward zero and accumulates the rotation angle.
// ----------------------------------------------------------------------------
module q2e_cordic_cell (
    input  logic                          i_clk,
    input  logic [q2e_pkg::SHW-1:0]       i_shift,
    input  logic signed [q2e_pkg::ZW-1:0] i_atan,
    input  q2e_pkg::t_cordic_lane         i_lane,
    output q2e_pkg::t_cordic_lane         o_lane
);
    import q2e_pkg::*;

    t_cordic_lane         r_lane;
    t_cordic_lane         n_lane;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    always_comb begin
        dx          = i_lane.y >>> i_shift;
        dy          = i_lane.x >>> i_shift;
        n_lane.zero = i_lane.zero;
        if (!i_lane.y[XW-1]) begin
            n_lane.x = i_lane.x + dx;
            n_lane.y = i_lane.y - dy;
            n_lane.z = i_lane.z + i_atan;
        end else begin
            n_lane.x = i_lane.x - dx;
            n_lane.y = i_lane.y + dy;
            n_lane.z = i_lane.z - i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

/* src/quaternion_to_euler.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler: attitude quaternion to ZYX Euler angles
// Roll and yaw by atan2, pitch by asin as atan2(s, sqrt(1 - s^2)), all in
// pipelined CORDIC chains; the pitch sine is clamped to [-1, 1] and flagged.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload                      direction
//  request   i_start / o_busy   i_req  (w, x, y, z, Q2.30)   in
//  result    o_valid strobe     o_res  (roll, pitch, yaw,    out
//                                       Q3.29, clamp flag)
//
//  One request per cycle, every cycle; o_busy is always low.
//  Requests pass the input, product, sum and square registers, the square
//  root chain, the quadrant fold, the CORDIC chain and the output register.
//  o_valid is high for one cycle with each result; the receiver cannot stall.
//  Reset clears only the valid pipe; data stages carry no reset.
//
module quaternion_to_euler (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  q2e_pkg::t_quat_req   i_req,
    output logic                 o_busy,
    output logic                 o_valid,
    output q2e_pkg::t_euler_res  o_res
);
    import q2e_pkg::*;

    localparam int LAT = 6 + SQD + STEPS;

    logic           accept;
    logic [LAT-1:0] r_vld;

    assign o_busy = 1'b0;
    assign accept = i_start & ~o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // Stage 0: components to Q2.30
    logic signed [31:0] r_qw, r_qx, r_qy, r_qz;

    always_ff @(posedge i_clk) begin
        r_qw <= to_q30(i_req.quat_w);
        r_qx <= to_q30(i_req.quat_x);
        r_qy <= to_q30(i_req.quat_y);
        r_qz <= to_q30(i_req.quat_z);
    end

    // Stage 1: products, exact Q4.60
    logic signed [63:0] r_p_wy, r_p_zx, r_p_wx, r_p_yz, r_p_xx;
    logic signed [63:0] r_p_yy, r_p_wz, r_p_xy, r_p_zz;

    always_ff @(posedge i_clk) begin
        r_p_wy <= r_qw * r_qy;
        r_p_zx <= r_qz * r_qx;
        r_p_wx <= r_qw * r_qx;
        r_p_yz <= r_qy * r_qz;
        r_p_xx <= r_qx * r_qx;
        r_p_yy <= r_qy * r_qy;
        r_p_wz <= r_qw * r_qz;
        r_p_xy <= r_qx * r_qy;
        r_p_zz <= r_qz * r_qz;
    end

    // Stage 2: doubled sums in Q.58 (half products added), sine clamp
    logic signed [63:0] s_raw, s_cl, num_r, den_r, num_y, den_y;
    logic               clamp;
    t_side              r_side2;
    logic signed [31:0] r_s30;

    always_comb begin
        s_raw = (r_p_wy >>> 1) - (r_p_zx >>> 1);
        num_r = (r_p_wx >>> 1) + (r_p_yz >>> 1);
        den_r = ONE_Q58 - ((r_p_xx >>> 1) + (r_p_yy >>> 1));
        num_y = (r_p_wz >>> 1) + (r_p_xy >>> 1);
        den_y = ONE_Q58 - ((r_p_yy >>> 1) + (r_p_zz >>> 1));
        priority if (s_raw > ONE_Q58) begin
            s_cl  = ONE_Q58;
            clamp = 1'b1;
        end else if (s_raw < -ONE_Q58) begin
            s_cl  = -ONE_Q58;
            clamp = 1'b1;
        end else begin
            s_cl  = s_raw;
            clamp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side2.roll_y <= OPW'(num_r >>> 8);
        r_side2.roll_x <= OPW'(den_r >>> 8);
        r_side2.yaw_y  <= OPW'(num_y >>> 8);
        r_side2.yaw_x  <= OPW'(den_y >>> 8);
        r_side2.sin_y  <= OPW'(s_cl >>> 8);
        r_side2.clamp  <= clamp;
        r_s30          <= s_cl[59:28];
    end

    // Stage 3: s^2 in Q.60
    logic signed [63:0] r_sq;
    t_side              r_side3;

    always_ff @(posedge i_clk) begin
        r_sq    <= r_s30 * r_s30;
        r_side3 <= r_side2;
    end

    // Square root chain: cos = floor(sqrt(2^60 - s^2)), one digit per cell
    t_sqrt_lane w_sq [SQD+1];
    logic [60:0] rad_in;
    t_side       r_side_d [SQD];

    assign rad_in        = 61'(61'd1 << 60) - r_sq[60:0];
    assign w_sq[0].rem   = '0;
    assign w_sq[0].root  = '0;
    assign w_sq[0].rad   = RADW'(rad_in);

    for (genvar k = 0; k < SQD; k++) begin : g_sqrt
        q2e_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_lane (w_sq[k]),
            .o_lane (w_sq[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_side_d[0] <= r_side3;
        for (int k = 1; k < SQD; k++) begin
            r_side_d[k] <= r_side_d[k-1];
        end
    end

    // Quadrant fold; pitch x operand is cos scaled to Q.50
    t_cordic_lane         r_pre_roll, r_pre_pitch, r_pre_yaw;
    logic [STEPS:0]       r_clamp_d;
    logic signed [XW-1:0] pitch_x;

    assign pitch_x = XW'({w_sq[SQD].root, 20'b0});

    always_ff @(posedge i_clk) begin
        r_pre_roll  <= prerot(r_side_d[SQD-1].roll_y, XW'(r_side_d[SQD-1].roll_x));
        r_pre_pitch <= prerot(r_side_d[SQD-1].sin_y, pitch_x);
        r_pre_yaw   <= prerot(r_side_d[SQD-1].yaw_y, XW'(r_side_d[SQD-1].yaw_x));
        r_clamp_d   <= {r_clamp_d[STEPS-1:0], r_side_d[SQD-1].clamp};
    end

    // CORDIC chains, three lanes side by side
    t_cordic_lane w_roll  [STEPS+1];
    t_cordic_lane w_pitch [STEPS+1];
    t_cordic_lane w_yaw   [STEPS+1];

    assign w_roll[0]  = r_pre_roll;
    assign w_pitch[0] = r_pre_pitch;
    assign w_yaw[0]   = r_pre_yaw;

    for (genvar k = 0; k < STEPS; k++) begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN = atan_q60(k);
        localparam logic [SHW-1:0]       SH   = SHW'(k);

        q2e_cordic_cell u_roll (
            .i_clk   (i_clk),
            .i_shift (SH),
            .i_atan  (ATAN),
            .i_lane  (w_roll[k]),
            .o_lane  (w_roll[k+1])
        );
        q2e_cordic_cell u_pitch (
            .i_clk   (i_clk),
            .i_shift (SH),
            .i_atan  (ATAN),
            .i_lane  (w_pitch[k]),
            .o_lane  (w_pitch[k+1])
        );
        q2e_cordic_cell u_yaw (
            .i_clk   (i_clk),
            .i_shift (SH),
            .i_atan  (ATAN),
            .i_lane  (w_yaw[k]),
            .o_lane  (w_yaw[k+1])
        );
    end

    // Output register: round to Q3.29; clamp flag tap lines up with the
    // last rotation stage
    always_ff @(posedge i_clk) begin
        o_res.roll_angle    <= round_q29(w_roll[STEPS]);
        o_res.pitch_angle   <= round_q29(w_pitch[STEPS]);
        o_res.yaw_angle     <= round_q29(w_yaw[STEPS]);
        o_res.pitch_clamped <= r_clamp_d[STEPS];
    end

    assign o_valid = r_vld[LAT-1];

endmodule

/* sim/quaternion_to_euler_tb.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_tb: self-checking bench for the quaternion converter
// Drives quaternions through the start/busy request port, predicts roll,
// pitch, yaw and the clamp flag bit-exactly, and checks every result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quaternion_to_euler_tb;
    import q2e_pkg::*;

    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam longint HALF_Q30 = 64'sd1 << 29;
    localparam int DRAIN_CYCLES = 6 + SQD + STEPS + 20;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    t_quat_req  i_req;
    logic       o_busy;
    logic       o_valid;
    t_euler_res o_res;

    t_euler_res angles_pending[$];
    longint     atan_step[STEPS];
    int         fail_count;
    bit         no_gaps;

    quaternion_to_euler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Component to Q2.30, whatever the port width
    function automatic longint comp_q30(input logic signed [CW-1:0] c);
        longint v;
        v = longint'(c);
        if (CW >= 32) begin
            v = v >>> (CW - 32);
        end else begin
            v = v * (64'sd1 << (32 - CW));
        end
        return v;
    endfunction

    // atan(2^-i) in Q.60: series terms truncated in Q.62
    function automatic longint atan_series(input int i);
        longint unsigned acc;
        longint unsigned term;
        bit add;
        acc = 0;
        add = 1'b1;
        if (i == 0) begin
            return PI_Q60 / 4;
        end
        for (int n = 1; i * n <= 62; n += 2) begin
            term = (64'd1 << (62 - i * n)) / longint'(n);
            acc  = add ? acc + term : acc - term;
            add  = !add;
        end
        return longint'(acc >> 2);
    endfunction

    // Vectoring CORDIC, operands Q.50, result rounded to Q3.29
    function automatic logic signed [31:0] vector_angle(input longint y, input longint x);
        longint ang;
        longint dx;
        longint dy;
        longint rounded;
        ang = 0;
        if (x == 0 && y == 0) begin
            return 32'sd0;
        end
        if (x < 0) begin
            ang = (y >= 0) ? PI_Q60 : -PI_Q60;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                ang += atan_step[i];
            end else begin
                x -= dx;
                y += dy;
                ang -= atan_step[i];
            end
        end
        rounded = (ang + (64'sd1 << 30)) >>> 31;
        return rounded[31:0];
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint half_product(input longint a, input longint b);
        return (a * b) >>> 1;
    endfunction

    function automatic t_euler_res euler_of(input t_quat_req q);
        t_euler_res r;
        longint w, x, y, z, s, num, den, s30;
        longint unsigned c30;
        w = comp_q30(q.quat_w);
        x = comp_q30(q.quat_x);
        y = comp_q30(q.quat_y);
        z = comp_q30(q.quat_z);
        r.pitch_clamped = 1'b0;
        // pitch sine 2(wy - zx), clamped to +-1 in Q.58
        s = half_product(w, y) - half_product(z, x);
        if (s > ONE_Q58) begin
            s = ONE_Q58;
            r.pitch_clamped = 1'b1;
        end else if (s < -ONE_Q58) begin
            s = -ONE_Q58;
            r.pitch_clamped = 1'b1;
        end
        num = half_product(w, x) + half_product(y, z);
        den = ONE_Q58 - (half_product(x, x) + half_product(y, y));
        r.roll_angle = vector_angle(num >>> 8, den >>> 8);
        // cosine from sqrt(1 - s^2) at Q.30, lifted to Q.50
        s30 = s >>> 28;
        c30 = root_floor((64'd1 << 60) - longint'(s30 * s30));
        r.pitch_angle = vector_angle(s >>> 8, longint'(c30) * (64'sd1 << 20));
        num = half_product(w, z) + half_product(x, y);
        den = ONE_Q58 - (half_product(y, y) + half_product(z, z));
        r.yaw_angle = vector_angle(num >>> 8, den >>> 8);
        return r;
    endfunction

    // One request: drive at the falling edge, held until accepted
    task automatic send_quat(input longint w, input longint x, input longint y, input longint z);
        int gap;
        @(negedge i_clk);
        i_req.quat_w = w[CW-1:0];
        i_req.quat_x = x[CW-1:0];
        i_req.quat_y = y[CW-1:0];
        i_req.quat_z = z[CW-1:0];
        i_start = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        angles_pending.push_back(euler_of(i_req));
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            @(negedge i_clk);
            i_start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_start = 1'b0;
        while (angles_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic longint rand_full();
        return longint'($signed($urandom()));
    endfunction

    // Roughly unit-scale component, within +-1.0
    function automatic longint rand_unit();
        return longint'($urandom_range(0, 2 * ONE_Q30)) - ONE_Q30;
    endfunction

    // Corner quaternions: identity, extremes, zero atan2 operands, pi fold,
    // pitch at exactly +-1 (zero cosine), clamped pitch both ways
    task automatic test_directed();
        longint mx, mn;
        mx = 64'sd2147483647;
        mn = -64'sd2147483648;
        send_quat(ONE_Q30, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(0, HALF_Q30, HALF_Q30, 0);
        send_quat(0, ONE_Q30, 0, 0);
        send_quat(0, 0, 0, ONE_Q30);
        send_quat(-1, ONE_Q30, 0, 0);
        send_quat(ONE_Q30, 0, HALF_Q30, 0);
        send_quat(ONE_Q30, 0, -HALF_Q30, 0);
        send_quat(mx, mx, mx, mx);
        send_quat(mn, mn, mn, mn);
        send_quat(mx, mn, mx, mn);
        send_quat(mn, mx, mn, mx);
        send_quat(mx, 0, mx, 0);
        send_quat(mx, 0, mn, 0);
        send_quat(0, mx, 0, mx);
        send_quat(0, mn, 0, mx);
        send_quat(-ONE_Q30, 0, 0, 0);
        send_quat(HALF_Q30, -HALF_Q30, HALF_Q30, -HALF_Q30);
        send_quat(1, -1, 1, -1);
        send_quat(-1, -1, -1, -1);
    endtask

    task automatic test_unit_attitudes(input int count);
        for (int k = 0; k < count; k++) begin
            send_quat(rand_unit(), rand_unit(), rand_unit(), rand_unit());
        end
    endtask

    task automatic test_full_range(input int count);
        for (int k = 0; k < count; k++) begin
            send_quat(rand_full(), rand_full(), rand_full(), rand_full());
        end
    endtask

    // Back-to-back requests, one per cycle
    task automatic test_streaming(input int count);
        no_gaps = 1'b1;
        test_unit_attitudes(count / 2);
        test_full_range(count / 2);
        no_gaps = 1'b0;
    endtask

    // Result checker: expectations are compared in order of arrival
    always @(posedge i_clk) begin
        t_euler_res exp_res;
        if (i_rst_n && o_valid) begin
            if (angles_pending.size() == 0) begin
                $error("result with nothing outstanding: roll %0d", o_res.roll_angle);
                fail_count++;
            end else begin
                exp_res = angles_pending.pop_front();
                if (o_res.roll_angle !== exp_res.roll_angle) begin
                    $error("roll_angle exp %0d got %0d", exp_res.roll_angle, o_res.roll_angle);
                    fail_count++;
                end
                if (o_res.pitch_angle !== exp_res.pitch_angle) begin
                    $error("pitch_angle exp %0d got %0d",
                           exp_res.pitch_angle, o_res.pitch_angle);
                    fail_count++;
                end
                if (o_res.yaw_angle !== exp_res.yaw_angle) begin
                    $error("yaw_angle exp %0d got %0d", exp_res.yaw_angle, o_res.yaw_angle);
                    fail_count++;
                end
                if (o_res.pitch_clamped !== exp_res.pitch_clamped) begin
                    $error("pitch_clamped exp %0b got %0b",
                           exp_res.pitch_clamped, o_res.pitch_clamped);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        fail_count = 0;
        no_gaps    = 1'b0;
        i_start    = 1'b0;
        i_req      = '0;
        i_rst_n    = 1'b0;
        for (int i = 0; i < STEPS; i++) atan_step[i] = atan_series(i);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        drain_results();          // sender holds off until all results are back
        test_unit_attitudes(450);
        test_streaming(200);
        test_full_range(280);
        drain_results();

        if (angles_pending.size() == 0 && fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
